// File: hdl/two_link_inverse_kinematics_macros.svh
// ----------------------------------------------------------------------------
// two_link_inverse_kinematics_macros
// assertion macros shared by the inverse kinematics modules
// ----------------------------------------------------------------------------
`ifndef TWO_LINK_INVERSE_KINEMATICS_MACROS_SVH
`define TWO_LINK_INVERSE_KINEMATICS_MACROS_SVH

// same-cycle implication, reset masked
`define TLIK_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tlik check failed");

// next-cycle implication, reset masked
`define TLIK_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tlik check failed");

`endif

// File: hdl/tlik_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlik_pkg
// types, constants and tables of the two-link inverse kinematics pipeline
// ----------------------------------------------------------------------------
package tlik_pkg;

    localparam int CORDIC_ITERATIONS_DEF = 16;
    localparam int DIV_CELLS             = 30;
    localparam int SQA_CELLS             = 31;
    localparam int SQB_CELLS             = 24;
    localparam int TOP_STAGES            = 9;

    localparam int LINK_W  = 15;
    localparam int COORD_W = 16;
    localparam int ANGLE_W = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_LINK  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_LINK = 2'd1;

    localparam logic [LINK_W-1:0] FIRST_LINK_RST  = 15'd1280;
    localparam logic [LINK_W-1:0] SECOND_LINK_RST = 15'd1024;

    localparam logic signed [25:0] Z_90 = 26'sd5898240;

    typedef struct packed {
        logic signed [35:0] x;
        logic signed [35:0] y;
        logic signed [25:0] z;
    } vec_t;

    typedef struct packed {
        logic        unr;
        logic        neg;
        logic        full;
        logic [31:0] r2;
        logic [30:0] den;
        logic [30:0] cmag;
        logic [30:0] s;
        logic [22:0] bs;
        logic [63:0] wv;
        logic [35:0] wr;
        logic [31:0] wq;
        vec_t [2:0]  vec;
    } item_t;

    // atan(2^-i) in 2^-16 degree
    function automatic logic [21:0] atan_entry(input int idx);
        logic [21:0] v;
        case (idx)
            0:  v = 22'd2949120;
            1:  v = 22'd1740967;
            2:  v = 22'd919879;
            3:  v = 22'd466945;
            4:  v = 22'd234379;
            5:  v = 22'd117304;
            6:  v = 22'd58666;
            7:  v = 22'd29335;
            8:  v = 22'd14668;
            9:  v = 22'd7334;
            10: v = 22'd3667;
            11: v = 22'd1833;
            12: v = 22'd917;
            13: v = 22'd458;
            14: v = 22'd229;
            15: v = 22'd115;
            16: v = 22'd57;
            17: v = 22'd29;
            18: v = 22'd14;
            19: v = 22'd7;
            20: v = 22'd4;
            21: v = 22'd2;
            22: v = 22'd1;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

    // quarter turn into the right half plane
    function automatic vec_t prerot(input vec_t v);
        vec_t r;
        r = v;
        r.z = '0;
        if (v.x < 0)
        begin
            if (v.y >= 0)
            begin
                r.x = v.y;
                r.y = -v.x;
                r.z = Z_90;
            end
            else
            begin
                r.x = -v.y;
                r.y = v.x;
                r.z = -Z_90;
            end
        end
        return r;
    endfunction

endpackage

// File: hdl/two_link_inverse_kinematics.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_link_inverse_kinematics
// planar two-link inverse kinematics, target point to two servo angles
// ----------------------------------------------------------------------------
// Takes one target word per cycle while s_tready is high and returns one
// angle word per word, in order, through nine single stages, 30 division
// cells for the elbow cosine, 31 and 24 square root cells, and one CORDIC
// cell per iteration. Each cell holds its own word and passes it on when the
// next cell has room, so a stalled output only fills the chain up behind it.
// Link lengths are written over the cfg channel into registers; the user must
// write them only while the pipeline is empty; the block does not enforce it.
`include "two_link_inverse_kinematics_macros.svh"
module two_link_inverse_kinematics
#(
    parameter int CORDIC_ITERATIONS = tlik_pkg::CORDIC_ITERATIONS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // target_x, target_y
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // shoulder_angle, elbow_servo_angle
    output logic        m_tuser,   // unreachable
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [tlik_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tlik_pkg::LINK_W-1:0]    cfg_data
);

    localparam int NS = tlik_pkg::TOP_STAGES;
    localparam int ND = tlik_pkg::DIV_CELLS;
    localparam int NA = tlik_pkg::SQA_CELLS;
    localparam int NB = tlik_pkg::SQB_CELLS;
    localparam int NC = CORDIC_ITERATIONS;

    logic [tlik_pkg::LINK_W-1:0] a_reg;
    logic [tlik_pkg::LINK_W-1:0] b_reg;
    logic [29:0]                 aa_reg;
    logic [29:0]                 bb_reg;
    logic [29:0]                 ab_reg;

    logic            t_v_reg   [1:NS];
    tlik_pkg::item_t t_p_reg   [1:NS];
    tlik_pkg::item_t t_p_next  [1:NS];
    logic            t_vin     [1:NS];
    tlik_pkg::item_t t_pin     [2:NS];
    logic            t_rdy     [1:NS];
    logic            t_rdy_out [1:NS];

    logic            d_v [0:ND];
    logic            d_r [0:ND];
    tlik_pkg::item_t d_p [0:ND];
    logic            qa_v [0:NA];
    logic            qa_r [0:NA];
    tlik_pkg::item_t qa_p [0:NA];
    logic            qb_v [0:NB];
    logic            qb_r [0:NB];
    tlik_pkg::item_t qb_p [0:NB];
    logic            c_v [0:NC];
    logic            c_r [0:NC];
    tlik_pkg::item_t c_p [0:NC];

    logic signed [15:0] tx;
    logic signed [15:0] ty;
    logic signed [31:0] xx;
    logic signed [31:0] yy;
    logic signed [33:0] num;
    logic [33:0]        mag34;
    logic [31:0]        mag;
    logic [30:0]        cm3;
    logic [45:0]        bprod;
    logic [47:0]        rr;
    logic [47:0]        rad;
    logic [35:0]        cm8;
    logic signed [27:0] shoulder;
    logic signed [27:0] elbow;
    logic signed [27:0] sh_rnd;
    logic signed [27:0] el_rnd;

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg <= tlik_pkg::FIRST_LINK_RST;
            b_reg <= tlik_pkg::SECOND_LINK_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                tlik_pkg::CFG_FIRST_LINK:  a_reg <= cfg_data;
                tlik_pkg::CFG_SECOND_LINK: b_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        aa_reg <= a_reg * a_reg;
        bb_reg <= b_reg * b_reg;
        ab_reg <= a_reg * b_reg;
    end

    // single stages
    for (genvar k = 1; k <= NS; k++)
    begin : g_stage
        assign t_rdy[k] = !t_v_reg[k] || t_rdy_out[k];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                t_v_reg[k] <= 1'b0;
            else if (t_rdy[k])
                t_v_reg[k] <= t_vin[k];
        end

        always_ff @(posedge clk)
        begin
            if (t_rdy[k] && t_vin[k])
                t_p_reg[k] <= t_p_next[k];
        end
    end

    // chain wiring
    assign t_vin[1]     = s_tvalid;
    assign s_tready     = t_rdy[1];
    assign t_vin[2]     = t_v_reg[1];
    assign t_pin[2]     = t_p_reg[1];
    assign t_rdy_out[1] = t_rdy[2];

    assign d_v[0]       = t_v_reg[2];
    assign d_p[0]       = t_p_reg[2];
    assign t_rdy_out[2] = d_r[0];
    assign t_vin[3]     = d_v[ND];
    assign t_pin[3]     = d_p[ND];
    assign d_r[ND]      = t_rdy[3];

    assign t_vin[4]     = t_v_reg[3];
    assign t_pin[4]     = t_p_reg[3];
    assign t_rdy_out[3] = t_rdy[4];

    assign qa_v[0]      = t_v_reg[4];
    assign qa_p[0]      = t_p_reg[4];
    assign t_rdy_out[4] = qa_r[0];
    assign t_vin[5]     = qa_v[NA];
    assign t_pin[5]     = qa_p[NA];
    assign qa_r[NA]     = t_rdy[5];

    assign t_vin[6]     = t_v_reg[5];
    assign t_pin[6]     = t_p_reg[5];
    assign t_rdy_out[5] = t_rdy[6];
    assign t_vin[7]     = t_v_reg[6];
    assign t_pin[7]     = t_p_reg[6];
    assign t_rdy_out[6] = t_rdy[7];

    assign qb_v[0]      = t_v_reg[7];
    assign qb_p[0]      = t_p_reg[7];
    assign t_rdy_out[7] = qb_r[0];
    assign t_vin[8]     = qb_v[NB];
    assign t_pin[8]     = qb_p[NB];
    assign qb_r[NB]     = t_rdy[8];

    assign c_v[0]       = t_v_reg[8];
    assign c_p[0]       = t_p_reg[8];
    assign t_rdy_out[8] = c_r[0];
    assign t_vin[9]     = c_v[NC];
    assign t_pin[9]     = c_p[NC];
    assign c_r[NC]      = t_rdy[9];

    assign t_rdy_out[9] = m_tready;
    assign m_tvalid     = t_v_reg[9];
    assign m_tdata      = t_p_reg[9].wq;
    assign m_tuser      = t_p_reg[9].unr;

    for (genvar i = 0; i < ND; i++)
    begin : g_div
        tlik_div_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (d_v[i]),
            .in_ready  (d_r[i]),
            .in_item   (d_p[i]),
            .out_valid (d_v[i+1]),
            .out_ready (d_r[i+1]),
            .out_item  (d_p[i+1])
        );
    end

    for (genvar i = 0; i < NA; i++)
    begin : g_sqa
        tlik_sqrt_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (qa_v[i]),
            .in_ready  (qa_r[i]),
            .in_item   (qa_p[i]),
            .out_valid (qa_v[i+1]),
            .out_ready (qa_r[i+1]),
            .out_item  (qa_p[i+1])
        );
    end

    for (genvar i = 0; i < NB; i++)
    begin : g_sqb
        tlik_sqrt_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (qb_v[i]),
            .in_ready  (qb_r[i]),
            .in_item   (qb_p[i]),
            .out_valid (qb_v[i+1]),
            .out_ready (qb_r[i+1]),
            .out_item  (qb_p[i+1])
        );
    end

    for (genvar i = 0; i < NC; i++)
    begin : g_cordic
        tlik_cordic_cell #(.ITER(i)) u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (c_v[i]),
            .in_ready  (c_r[i]),
            .in_item   (c_p[i]),
            .out_valid (c_v[i+1]),
            .out_ready (c_r[i+1]),
            .out_item  (c_p[i+1])
        );
    end

    // radius squared, theta vector
    assign tx = $signed(s_tdata[15:0]);
    assign ty = $signed(s_tdata[31:16]);
    assign xx = tx * tx;
    assign yy = ty * ty;

    always_comb
    begin
        t_p_next[1] = '0;
        t_p_next[1].r2 = $unsigned(xx) + $unsigned(yy);
        t_p_next[1].vec[0].x = $signed({{4{tx[15]}}, tx, 16'b0});
        t_p_next[1].vec[0].y = $signed({{4{ty[15]}}, ty, 16'b0});
    end

    // cosine numerator, reach check
    assign num   = $signed({2'b0, t_pin[2].r2}) - $signed({4'b0, aa_reg})
                 - $signed({4'b0, bb_reg});
    assign mag34 = num[33] ? $unsigned(-num) : $unsigned(num);
    assign mag   = mag34[31:0];

    always_comb
    begin
        t_p_next[2] = t_pin[2];
        t_p_next[2].den  = {ab_reg, 1'b0};
        t_p_next[2].neg  = num[33];
        t_p_next[2].full = (mag34 == {3'b0, ab_reg, 1'b0});
        t_p_next[2].unr  = (t_pin[2].r2 == '0) || (ab_reg == '0)
                         || (mag34 > {3'b0, ab_reg, 1'b0});
        t_p_next[2].wr   = t_p_next[2].full ? '0 : {4'b0, mag};
        t_p_next[2].wq   = '0;
    end

    // cosine magnitude and its square
    assign cm3 = t_pin[3].full ? 31'h40000000 : {1'b0, t_pin[3].wq[29:0]};

    always_comb
    begin
        t_p_next[3] = t_pin[3];
        t_p_next[3].cmag = cm3;
        t_p_next[3].wv   = {2'b0, 62'(cm3) * 62'(cm3)};
    end

    // sine radicand
    always_comb
    begin
        t_p_next[4] = t_pin[4];
        t_p_next[4].wv = ((64'd1 << 60) - t_pin[4].wv) << 2;
        t_p_next[4].wr = '0;
        t_p_next[4].wq = '0;
    end

    // b times sine
    assign bprod = b_reg * t_pin[5].wq[30:0];

    always_comb
    begin
        t_p_next[5] = t_pin[5];
        t_p_next[5].s  = t_pin[5].wq[30:0];
        t_p_next[5].bs = bprod[44:22];
    end

    always_comb
    begin
        t_p_next[6] = t_pin[6];
        t_p_next[6].wv = {18'b0, 46'(t_pin[6].bs) * 46'(t_pin[6].bs)};
    end

    // offset radicand, clamped at zero
    assign rr  = {t_pin[7].r2, 16'b0};
    assign rad = (rr > t_pin[7].wv[47:0]) ? (rr - t_pin[7].wv[47:0]) : '0;

    always_comb
    begin
        t_p_next[7] = t_pin[7];
        t_p_next[7].wv = {rad, 16'b0};
        t_p_next[7].wr = '0;
        t_p_next[7].wq = '0;
    end

    // cordic operands
    assign cm8 = {5'b0, t_pin[8].cmag};

    always_comb
    begin
        tlik_pkg::vec_t v1;
        tlik_pkg::vec_t v2;
        v1 = '0;
        v2 = '0;
        v1.x = t_pin[8].neg ? -$signed(cm8) : $signed(cm8);
        v1.y = $signed({5'b0, t_pin[8].s});
        v2.x = $signed({4'b0, t_pin[8].wq[23:0], 8'b0});
        v2.y = $signed({5'b0, t_pin[8].bs, 8'b0});
        t_p_next[8] = t_pin[8];
        t_p_next[8].vec[0] = tlik_pkg::prerot(t_pin[8].vec[0]);
        t_p_next[8].vec[1] = tlik_pkg::prerot(v1);
        t_p_next[8].vec[2] = tlik_pkg::prerot(v2);
    end

    // final angles, rounded to 1/64 degree
    assign shoulder = $signed({{2{t_pin[9].vec[0].z[25]}}, t_pin[9].vec[0].z})
                    + $signed({{2{t_pin[9].vec[2].z[25]}}, t_pin[9].vec[2].z});
    assign elbow    = $signed({{2{t_pin[9].vec[1].z[25]}}, t_pin[9].vec[1].z}) - shoulder;
    assign sh_rnd   = shoulder + 28'sd512;
    assign el_rnd   = elbow + 28'sd512;

    always_comb
    begin
        t_p_next[9] = t_pin[9];
        if (t_pin[9].unr)
            t_p_next[9].wq = '0;
        else
            t_p_next[9].wq = {el_rnd[25:10], sh_rnd[25:10]};
    end

    `TLIK_ASSERT_IMP(a_unreachable_zero, m_tvalid && m_tuser, m_tdata == '0)
    `TLIK_ASSERT_IMP(a_empty_out_takes_input, !m_tvalid, s_tready)
    `TLIK_ASSERT_NXT(a_out_drains, m_tvalid && m_tready && !t_vin[NS], !m_tvalid)

endmodule

// File: hdl/tlik_div_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlik_div_cell
// one restoring division step of the elbow cosine quotient
// ----------------------------------------------------------------------------
`include "two_link_inverse_kinematics_macros.svh"
module tlik_div_cell
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  tlik_pkg::item_t in_item,
    output logic            out_valid,
    input  logic            out_ready,
    output tlik_pkg::item_t out_item
);

    logic            valid_reg;
    tlik_pkg::item_t item_reg;
    tlik_pkg::item_t item_next;
    logic [35:0]     rem2;
    logic [35:0]     dext;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_comb
    begin
        item_next = in_item;
        rem2 = {in_item.wr[34:0], 1'b0};
        dext = {5'b0, in_item.den};
        if (rem2 >= dext)
        begin
            item_next.wr = rem2 - dext;
            item_next.wq = {in_item.wq[30:0], 1'b1};
        end
        else
        begin
            item_next.wr = rem2;
            item_next.wq = {in_item.wq[30:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            item_reg <= item_next;
    end

    `TLIK_ASSERT_IMP(a_div_rem_below_den, valid_reg && !item_reg.unr,
        item_reg.wr < {5'b0, item_reg.den})

endmodule

// File: hdl/tlik_sqrt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlik_sqrt_cell
// one digit of a bit-pair integer square root
// ----------------------------------------------------------------------------
`include "two_link_inverse_kinematics_macros.svh"
module tlik_sqrt_cell
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  tlik_pkg::item_t in_item,
    output logic            out_valid,
    input  logic            out_ready,
    output tlik_pkg::item_t out_item
);

    logic            valid_reg;
    tlik_pkg::item_t item_reg;
    tlik_pkg::item_t item_next;
    logic [35:0]     rn;
    logic [35:0]     trial;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_comb
    begin
        item_next = in_item;
        rn    = {in_item.wr[33:0], in_item.wv[63:62]};
        trial = {2'b0, in_item.wq, 2'b01};
        item_next.wv = {in_item.wv[61:0], 2'b00};
        if (rn >= trial)
        begin
            item_next.wr = rn - trial;
            item_next.wq = {in_item.wq[30:0], 1'b1};
        end
        else
        begin
            item_next.wr = rn;
            item_next.wq = {in_item.wq[30:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            item_reg <= item_next;
    end

    `TLIK_ASSERT_IMP(a_sqrt_rem_bound, valid_reg,
        item_reg.wr <= {3'b0, item_reg.wq, 1'b0})

endmodule

// File: hdl/tlik_cordic_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlik_cordic_cell
// one vectoring micro-rotation for the three angle vectors
// ----------------------------------------------------------------------------
module tlik_cordic_cell
#(
    parameter int ITER = 0
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  tlik_pkg::item_t in_item,
    output logic            out_valid,
    input  logic            out_ready,
    output tlik_pkg::item_t out_item
);

    localparam logic signed [25:0] ANGLE = $signed({4'b0, tlik_pkg::atan_entry(ITER)});

    logic            valid_reg;
    tlik_pkg::item_t item_reg;
    tlik_pkg::item_t item_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_comb
    begin
        item_next = in_item;
        for (int k = 0; k < 3; k++)
        begin
            if (!in_item.vec[k].y[35])
            begin
                item_next.vec[k].x = in_item.vec[k].x + (in_item.vec[k].y >>> ITER);
                item_next.vec[k].y = in_item.vec[k].y - (in_item.vec[k].x >>> ITER);
                item_next.vec[k].z = in_item.vec[k].z + ANGLE;
            end
            else
            begin
                item_next.vec[k].x = in_item.vec[k].x - (in_item.vec[k].y >>> ITER);
                item_next.vec[k].y = in_item.vec[k].y + (in_item.vec[k].x >>> ITER);
                item_next.vec[k].z = in_item.vec[k].z - ANGLE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            item_reg <= item_next;
    end

endmodule
